[src/per_opcode_latency_histogram_macros.svh]
// Assertion macros used by the latency histogram checker.
`ifndef PER_OPCODE_LATENCY_HISTOGRAM_MACROS_SVH
`define PER_OPCODE_LATENCY_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLH_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLH_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[src/plh_pkg.sv]
// Types and constants shared by the latency histogram modules.
`default_nettype none

package plh_pkg;

	localparam int NUM_BUCKETS = 7;
	localparam int NUM_EDGES   = 6;

	// Bucket edges of 25, 50, 100, 200, 400 and 800 us, in nanoseconds.
	localparam logic [63:0] EDGE_NS [NUM_EDGES] = '{
		64'd25000, 64'd50000, 64'd100000, 64'd200000, 64'd400000, 64'd800000
	};

	localparam logic [1:0] MODE_NESTED = 2'd0;
	localparam logic [1:0] MODE_OUTER  = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_READ   = 2'd3;

	localparam logic [2:0] ST_RECORDED = 3'd0;
	localparam logic [2:0] ST_UNMAPPED = 3'd1;
	localparam logic [2:0] ST_UNTIMED  = 3'd2;
	localparam logic [2:0] ST_NEST_CLR = 3'd3;
	localparam logic [2:0] ST_READOUT  = 3'd4;

	localparam logic [3:0] WORD_OPCODE  = 4'd0;
	localparam logic [3:0] WORD_COUNT   = 4'd1;
	localparam logic [3:0] WORD_SUM     = 4'd2;
	localparam logic [3:0] WORD_MAX     = 4'd3;
	localparam logic [3:0] WORD_BUCKET0 = 4'd4;
	localparam logic [3:0] WORD_LAST    = 4'd10;

	localparam logic [1:0] REG_OLD_FIRST = 2'd0;
	localparam logic [1:0] REG_OLD_END   = 2'd1;
	localparam logic [1:0] REG_NEW_FIRST = 2'd2;
	localparam logic [1:0] REG_NEW_END   = 2'd3;

	typedef struct packed {
		logic [31:0] old_first;
		logic [31:0] old_end;
		logic [31:0] new_first;
		logic [31:0] new_end;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic mapped;
	} map_stat_t;

	typedef struct packed {
		logic [NUM_BUCKETS-1:0][63:0] bucket;
		logic [63:0]                  tmax;
		logic [63:0]                  tsum;
		logic [63:0]                  count;
		logic [31:0]                  opcode;
	} row_t;

endpackage

`default_nettype wire

[src/plh_table.sv]
// Slot table memory with a clearing sweep after reset.
`default_nettype none

module plh_table #(
	parameter int DEPTH  = 24576,
	parameter int ADDR_W = 15
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	output logic                   clearing,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output plh_pkg::row_t          rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire plh_pkg::row_t     wr_data
);
	import plh_pkg::*;

	row_t              ram [DEPTH];
	row_t              rd_data_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			ram[clr_addr_q] <= '0;
		end else if (wr_en) begin
			ram[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ram[rd_addr];
		end
	end

	assign clearing = clr_q;
	assign rd_data  = rd_data_q;

endmodule

`default_nettype wire

[src/plh_slot_map.sv]
// Opcode to slot mapping pipeline with a reciprocal fold of the tail range.
`default_nettype none

module plh_slot_map #(
	parameter int OLD_SPAN   = 16384,
	parameter int DENSE_SPAN = 4096,
	parameter int FOLD_SPAN  = 4096,
	parameter int SLOT_W     = 15
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req,
	input  wire logic [31:0]       opcode,
	input  wire plh_pkg::cfg_t     cfg,
	output plh_pkg::map_stat_t     stat,
	output logic [SLOT_W-1:0]      slot
);
	import plh_pkg::*;

	localparam int FOLD_LOG = $clog2(FOLD_SPAN);
	localparam int SHIFT    = 32 + FOLD_LOG;
	localparam int PROD_W   = SHIFT + 32;
	localparam int R_W      = FOLD_LOG + 1;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(FOLD_SPAN);
	localparam logic [32:0] RECIP      = RECIP_FULL[32:0];

	typedef enum logic [1:0] {
		K_NONE  = 2'd0,
		K_OLD   = 2'd1,
		K_DENSE = 2'd2,
		K_FOLD  = 2'd3
	} kind_t;

	logic              old_hit, new_hit;
	logic [31:0]       off_old, off_new;
	kind_t             kind_c;
	logic [31:0]       off_c;
	logic [31:0]       quot;
	logic [31:0]       rem_full;
	logic [R_W-1:0]    rem_fix;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	kind_t             kind_s1, kind_s2, kind_s3, kind_s4;
	logic [31:0]       off_s1, off_s2, off_s3, off_s4;
	logic [PROD_W-1:0] prod_s2;
	logic [31:0]       qf_s3;
	logic [R_W-1:0]    rem_s4;
	logic              mapped_s5;
	logic [SLOT_W-1:0] slot_s5;

	always_comb begin
		old_hit = (opcode >= cfg.old_first) && (opcode < cfg.old_end);
		new_hit = (opcode >= cfg.new_first) && (opcode < cfg.new_end);
		off_old = opcode - cfg.old_first;
		off_new = opcode - cfg.new_first;
		kind_c  = K_NONE;
		off_c   = off_new;
		if (old_hit) begin
			off_c  = off_old;
			kind_c = (off_old < 32'(OLD_SPAN)) ? K_OLD : K_NONE;
		end else if (new_hit) begin
			kind_c = (off_new < 32'(DENSE_SPAN)) ? K_DENSE : K_FOLD;
		end
	end

	assign quot     = prod_s2[SHIFT +: 32];
	assign rem_full = off_s3 - qf_s3;
	assign rem_fix  = (rem_s4 >= R_W'(FOLD_SPAN)) ? rem_s4 - R_W'(FOLD_SPAN) : rem_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_c;
		off_s1  <= off_c;

		kind_s2 <= kind_s1;
		off_s2  <= off_s1;
		prod_s2 <= PROD_W'(off_s1) * PROD_W'(RECIP);

		kind_s3 <= kind_s2;
		off_s3  <= off_s2;
		qf_s3   <= 32'(quot * 32'(FOLD_SPAN));

		kind_s4 <= kind_s3;
		off_s4  <= off_s3;
		rem_s4  <= R_W'(rem_full);

		mapped_s5 <= (kind_s4 != K_NONE);
		case (kind_s4)
			K_OLD:   slot_s5 <= SLOT_W'(off_s4);
			K_DENSE: slot_s5 <= SLOT_W'(OLD_SPAN) + SLOT_W'(off_s4);
			K_FOLD:  slot_s5 <= SLOT_W'(OLD_SPAN + DENSE_SPAN) + SLOT_W'(rem_fix);
			default: slot_s5 <= '0;
		endcase
	end

	assign stat.done   = v_s5;
	assign stat.mapped = mapped_s5;
	assign slot        = slot_s5;

endmodule

`default_nettype wire

[src/per_opcode_latency_histogram.sv]
// Top level of the per-opcode latency histogram.
//
// Requests enter on start when busy is low; mode selects a nested call end, an outer
// call end, a clear of the nesting time or a read-and-clear of one slot.
// Results leave on result_valid for one cycle each, with status, slot_index,
// word_index, value and last; last marks the final result of a request.
// The user must write the range registers through the APB port only while the
// block is idle; the block itself does not enforce this.
// A timed call end passes through a five-stage opcode map with a reciprocal
// multiply for the folded range, then one read and one write of the slot row in
// the table memory; no new request is taken until that write is done. An
// unmapped opcode gives its result when the map finishes and skips the table.
// A clear of nesting time or an untimed call gives its result in the next
// cycle, and a new request may follow at once.
// A read request gives eleven results, one per word of the row, and holds busy
// high while it steps through the words, so the next request is taken only
// after the read.
// After reset the table is swept to zero, one row per cycle, over all NUM_SLOTS
// rows (24576 with the default spans); busy stays high during the sweep.
// The receiver cannot stall; results are never held back.
`default_nettype none

module per_opcode_latency_histogram #(
	parameter int OLD_SPAN   = 16384,
	parameter int DENSE_SPAN = 4096,
	parameter int FOLD_SPAN  = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] opcode,
	input  wire logic [63:0] start_time,
	input  wire logic [63:0] stop_time,
	input  wire logic [14:0] read_slot,
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [14:0]      slot_index,
	output logic [3:0]       word_index,
	output logic [63:0]      value,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import plh_pkg::*;

	localparam int NUM_SLOTS = OLD_SPAN + DENSE_SPAN + FOLD_SPAN;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_TIME   = 5'b00010,
		S_MAP    = 5'b00100,
		S_UPDATE = 5'b01000,
		S_DUMP   = 5'b10000
	} state_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] sat_inc(input logic [63:0] a);
		return (&a) ? a : a + 64'd1;
	endfunction

	function automatic logic [2:0] bucket_of(input logic [63:0] t);
		logic [2:0] b;
		b = '0;
		for (int i = 0; i < NUM_EDGES; i++) begin
			if (t >= EDGE_NS[i]) begin
				b = b + 3'd1;
			end
		end
		return b;
	endfunction

	state_t            state_q;
	cfg_t              cfg_q;
	logic [63:0]       nested_q;
	logic [1:0]        mode_q;
	logic [31:0]       op_q;
	logic [63:0]       elapsed_q;
	logic [63:0]       dt_q;
	logic [2:0]        bkt_q;
	logic [SLOT_W-1:0] slot_q;
	logic [14:0]       rslot_q;
	logic              zero_q;
	logic [3:0]        word_q;

	logic              result_valid_q;
	logic [2:0]        status_q;
	logic [14:0]       slot_index_q;
	logic [3:0]        word_index_q;
	logic [63:0]       value_q;
	logic              last_q;

	logic              clearing;
	logic              accept;
	logic              timed;
	logic              in_range;
	logic              map_req;
	map_stat_t         map_stat;
	logic [SLOT_W-1:0] map_slot;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	row_t              rd_row;
	logic              wr_en;
	row_t              wr_row;
	row_t              upd_row;
	logic [63:0]       dump_value;
	logic              cfg_wr;

	logic              res_en;
	logic [2:0]        res_status;
	logic [14:0]       res_slot;
	logic [3:0]        res_word;
	logic [63:0]       res_value;
	logic              res_last;

	assign busy     = clearing || (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign timed    = (start_time != 64'd0);
	assign in_range = (32'(read_slot) < 32'(NUM_SLOTS));
	assign map_req  = accept && (mode == MODE_NESTED || mode == MODE_OUTER) && timed;

	assign rd_en   = (accept && mode == MODE_READ && in_range) ||
		(state_q == S_MAP && map_stat.done && map_stat.mapped);
	assign rd_addr = (state_q == S_MAP) ? map_slot : SLOT_W'(read_slot);

	assign wr_en  = (state_q == S_UPDATE) ||
		(state_q == S_DUMP && word_q == WORD_OPCODE && !zero_q);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	plh_slot_map #(
		.OLD_SPAN   (OLD_SPAN),
		.DENSE_SPAN (DENSE_SPAN),
		.FOLD_SPAN  (FOLD_SPAN),
		.SLOT_W     (SLOT_W)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.opcode (opcode),
		.cfg    (cfg_q),
		.stat   (map_stat),
		.slot   (map_slot)
	);

	plh_table #(
		.DEPTH  (NUM_SLOTS),
		.ADDR_W (SLOT_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_row),
		.wr_en    (wr_en),
		.wr_addr  (slot_q),
		.wr_data  (wr_row)
	);

	always_comb begin
		upd_row        = rd_row;
		upd_row.opcode = op_q;
		upd_row.count  = sat_inc(rd_row.count);
		upd_row.tsum   = sat_add(rd_row.tsum, dt_q);
		upd_row.tmax   = (dt_q > rd_row.tmax) ? dt_q : rd_row.tmax;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			if (3'(i) == bkt_q) begin
				upd_row.bucket[i] = sat_inc(rd_row.bucket[i]);
			end
		end
	end

	always_comb begin
		if (state_q == S_UPDATE) begin
			wr_row = upd_row;
		end else begin
			wr_row        = '0;
			wr_row.opcode = rd_row.opcode;
		end
	end

	always_comb begin
		case (word_q) inside
			WORD_OPCODE:                dump_value = {32'd0, rd_row.opcode};
			WORD_COUNT:                 dump_value = rd_row.count;
			WORD_SUM:                   dump_value = rd_row.tsum;
			WORD_MAX:                   dump_value = rd_row.tmax;
			[WORD_BUCKET0:WORD_LAST]:   dump_value = rd_row.bucket[3'(word_q - WORD_BUCKET0)];
			default:                    dump_value = '0;
		endcase
		if (zero_q) begin
			dump_value = '0;
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OLD_FIRST: prdata = cfg_q.old_first;
			REG_OLD_END:   prdata = cfg_q.old_end;
			REG_NEW_FIRST: prdata = cfg_q.new_first;
			REG_NEW_END:   prdata = cfg_q.new_end;
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		res_en     = 1'b0;
		res_status = ST_RECORDED;
		res_slot   = '0;
		res_word   = WORD_OPCODE;
		res_value  = '0;
		res_last   = 1'b1;
		if (accept && mode == MODE_CLEAR) begin
			res_en     = 1'b1;
			res_status = ST_NEST_CLR;
		end else if (accept && mode != MODE_READ && !timed) begin
			res_en     = 1'b1;
			res_status = ST_UNTIMED;
		end else if (state_q == S_MAP && map_stat.done && !map_stat.mapped) begin
			res_en     = 1'b1;
			res_status = ST_UNMAPPED;
		end else if (state_q == S_UPDATE) begin
			res_en     = 1'b1;
			res_slot   = 15'(slot_q);
		end else if (state_q == S_DUMP) begin
			res_en     = 1'b1;
			res_status = ST_READOUT;
			res_slot   = rslot_q;
			res_word   = word_q;
			res_value  = dump_value;
			res_last   = (word_q == WORD_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.old_first <= 32'd20000;
			cfg_q.old_end   <= 32'd30000;
			cfg_q.new_first <= 32'd200000000;
			cfg_q.new_end   <= 32'hFFFF_FFFF;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_OLD_FIRST: cfg_q.old_first <= pwdata;
				REG_OLD_END:   cfg_q.old_end   <= pwdata;
				REG_NEW_FIRST: cfg_q.new_first <= pwdata;
				REG_NEW_END:   cfg_q.new_end   <= pwdata;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			nested_q       <= '0;
			word_q         <= WORD_OPCODE;
			zero_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= res_en;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode) inside
							MODE_CLEAR: begin
								nested_q <= '0;
							end
							MODE_READ: begin
								zero_q  <= !in_range;
								word_q  <= WORD_OPCODE;
								state_q <= S_DUMP;
							end
							MODE_NESTED, MODE_OUTER: begin
								if (timed) begin
									state_q <= S_TIME;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_TIME: begin
					if (mode_q == MODE_NESTED) begin
						nested_q <= sat_add(nested_q, elapsed_q);
					end else begin
						nested_q <= '0;
					end
					state_q <= S_MAP;
				end
				S_MAP: begin
					if (map_stat.done) begin
						state_q <= map_stat.mapped ? S_UPDATE : S_IDLE;
					end
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
				end
				S_DUMP: begin
					word_q <= word_q + 4'd1;
					if (word_q == WORD_LAST) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode;
			op_q      <= opcode;
			elapsed_q <= stop_time - start_time;
			rslot_q   <= read_slot;
			slot_q    <= SLOT_W'(read_slot);
		end
		if (state_q == S_TIME) begin
			if (mode_q == MODE_NESTED) begin
				dt_q <= elapsed_q;
			end else begin
				dt_q <= (elapsed_q > nested_q) ? elapsed_q - nested_q : 64'd0;
			end
		end
		if (state_q == S_MAP) begin
			bkt_q <= bucket_of(dt_q);
			if (map_stat.done) begin
				slot_q <= map_slot;
			end
		end
		if (res_en) begin
			status_q     <= res_status;
			slot_index_q <= res_slot;
			word_index_q <= res_word;
			value_q      <= res_value;
			last_q       <= res_last;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign slot_index   = slot_index_q;
	assign word_index   = word_index_q;
	assign value        = value_q;
	assign last         = last_q;

endmodule

`default_nettype wire

[src/plh_checker.sv]
// Port-level checker for the latency histogram and its bind to the top level.
`default_nettype none

`include "per_opcode_latency_histogram_macros.svh"

module plh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  mode,
	input wire logic [63:0] start_time,
	input wire logic        result_valid,
	input wire logic [2:0]  status,
	input wire logic [3:0]  word_index,
	input wire logic [63:0] value,
	input wire logic        last
);
	import plh_pkg::*;

	`PLH_ASSERT_NEXT(a_readout_contiguous, clk, arst_n, result_valid && !last, result_valid && status == ST_READOUT && word_index == 4'($past(word_index) + 4'd1), "Readout words must follow one another without gaps")

	`PLH_ASSERT_IMP(a_single_result_last, clk, arst_n, result_valid && status != ST_READOUT, last && word_index == WORD_OPCODE && value == 64'd0, "A record result must be the only and last result of its request")

	`PLH_ASSERT_IMP(a_readout_ends_at_last_word, clk, arst_n, result_valid && status == ST_READOUT && last, word_index == WORD_LAST, "A readout must end on its last word")

	`PLH_ASSERT_NEXT(a_quick_result, clk, arst_n, start && !busy && (mode == MODE_CLEAR || (mode != MODE_READ && start_time == 64'd0)), result_valid && last && (status == ST_NEST_CLR || status == ST_UNTIMED), "A clear or untimed request must answer in the next cycle")

endmodule

bind per_opcode_latency_histogram plh_checker u_plh_checker (.*);

`default_nettype wire
